### src/bfa_pkg.sv
// Shared types, codes and helpers of the bitmap frame allocator.
package bfa_pkg;

    localparam int FRAME_W     = 20;
    localparam int COUNT_W     = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int MAPB_W      = 13;
    localparam int OFF_W       = FRAME_W + 1;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INIT    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_USED      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE = 2'd2;

    localparam logic [MAPB_W-1:0] MAPB_RESET = 13'd4096;
    localparam logic [7:0]        BYTE_FREE  = 8'hFF;
    localparam logic [7:0]        BYTE_RSVD  = 8'h7F;
    localparam logic [7:0]        BIT_FIRST  = 8'h80;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_LOCATE,
        FSM_CHECK,
        FSM_RESP
    } t_state;

    // Position of the first set bit counted from the MSB.
    function automatic logic [2:0] first_free(input logic [7:0] b);
        logic [2:0] pos;
        logic       hit;
        pos = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!hit && b[7-i]) begin
                pos = 3'(i);
                hit = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

### src/bitmap_frame_allocator_core.sv
// Bitmap frame allocator: first-fit single-frame allocate, range mark, release, init.
// Allocate scans the map from byte 0, one map byte a cycle, taking the first free frame it finds.
// Mark reads then writes back each frame in turn; release reads and writes back its one frame.
// Init writes one map byte per cycle through the write port.
// One request at a time; the next is taken while the last result still waits on the output.
// Reset (synchronous) clears control and runs a pass over the MAX_FRAMES/8 map bytes setting every byte free.
module bitmap_frame_allocator_core #(
    parameter int MAX_FRAMES = 32768
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // req_frame [19:0], count [35:20], zero fill [39:36]
    input  logic [bfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind [1:0]
    input  logic [bfa_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_frame [19:0], status [22:20], zero fill [23]
    output logic [bfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bfa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import bfa_pkg::*;

    localparam int MAP_DEPTH = MAX_FRAMES / 8;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int PB_W      = $clog2(MAP_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  r_chk_vld, n_chk_vld;
    logic [PB_W-1:0]       r_addr, n_addr;
    logic [ADDR_W-1:0]     r_sweep, n_sweep;
    logic                  r_init, n_init;

    logic [FRAME_W-1:0]    r_base;
    logic [MAPB_W-1:0]     r_map_bytes;
    logic                  r_reserve;

    logic [OFF_W-1:0]      r_frame, n_frame;
    logic [COUNT_W-1:0]    r_left, n_left;
    logic                  r_is_mark, n_is_mark;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [7:0]            r_mask, n_mask;
    logic [ADDR_W-1:0]     r_chk_addr, n_chk_addr;
    logic [FRAME_W-1:0]    r_res_frame, n_res_frame;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [FRAME_W-1:0]    r_out_frame, n_out_frame;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [7:0]            ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [7:0]            ram_rdata;

    logic [PB_W-1:0]       pool_bytes;
    logic [OFF_W-1:0]      pool_bits;
    logic [OFF_W-1:0]      base_ext;
    logic [OFF_W-1:0]      loc_off;
    logic                  loc_ok;
    logic [ADDR_W-1:0]     loc_idx;
    logic [7:0]            loc_mask;
    logic [2:0]            hit_bit;
    logic [7:0]            hit_mask;

    logic [KIND_W-1:0]     in_kind;
    logic [FRAME_W-1:0]    in_req_frame;
    logic [COUNT_W-1:0]    in_count;

    assign in_kind      = s_axis_tuser;
    assign in_req_frame = s_axis_tdata[FRAME_W-1:0];
    assign in_count     = s_axis_tdata[FRAME_W +: COUNT_W];

    bfa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pool_bytes = ({19'd0, r_map_bytes} >= 32'(MAP_DEPTH)) ?
                        PB_W'(MAP_DEPTH) : PB_W'(r_map_bytes);
    assign pool_bits  = OFF_W'({pool_bytes, 3'b000});
    assign base_ext   = {1'b0, r_base};
    assign loc_off    = r_frame - base_ext;
    assign loc_ok     = (r_frame >= base_ext) && (loc_off < pool_bits);
    assign loc_idx    = loc_off[ADDR_W+2:3];
    assign loc_mask   = BIT_FIRST >> loc_off[2:0];
    assign hit_bit    = first_free(ram_rdata);
    assign hit_mask   = BIT_FIRST >> hit_bit;
    assign ram_raddr  = (r_state == FSM_SCAN) ? r_addr[ADDR_W-1:0] : loc_idx;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_chk_vld    = r_chk_vld;
        n_addr       = r_addr;
        n_sweep      = r_sweep;
        n_init       = r_init;
        n_frame      = r_frame;
        n_left       = r_left;
        n_is_mark    = r_is_mark;
        n_idx        = r_idx;
        n_mask       = r_mask;
        n_chk_addr   = r_chk_addr;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;
        n_out_frame  = r_out_frame;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_sweep;
        ram_wdata    = BYTE_FREE;

        case (r_state)
            FSM_CLEAR: begin
                ram_we = 1'b1;
                if (r_init && r_reserve && (r_sweep == '0)) begin
                    ram_wdata = BYTE_RSVD;
                end
                n_sweep = ADDR_W'(r_sweep + 1'b1);
                if (r_sweep == LAST_ADDR) begin
                    n_sweep = '0;
                    if (r_init) begin
                        n_init       = 1'b0;
                        n_res_frame  = '0;
                        n_res_status = STAT_OK;
                        n_state      = FSM_RESP;
                    end else begin
                        n_state = FSM_IDLE;
                    end
                end
            end
            FSM_IDLE: begin
                if (s_axis_tvalid) begin
                    n_frame   = {1'b0, in_req_frame};
                    n_left    = in_count;
                    n_is_mark = (in_kind == KIND_MARK);
                    n_addr    = '0;
                    n_chk_vld = 1'b0;
                    case (in_kind)
                        KIND_ALLOC: begin
                            n_state = FSM_SCAN;
                        end
                        KIND_MARK: begin
                            if (in_count == '0) begin
                                n_res_frame  = '0;
                                n_res_status = STAT_OK;
                                n_state      = FSM_RESP;
                            end else begin
                                n_state = FSM_LOCATE;
                            end
                        end
                        KIND_RELEASE: begin
                            n_state = FSM_LOCATE;
                        end
                        KIND_INIT: begin
                            n_init  = 1'b1;
                            n_sweep = '0;
                            n_state = FSM_CLEAR;
                        end
                        default: begin
                            n_state = FSM_IDLE;
                        end
                    endcase
                end
            end
            FSM_SCAN: begin
                if (r_chk_vld && (ram_rdata != '0)) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_chk_addr;
                    ram_wdata    = ram_rdata & ~hit_mask;
                    n_res_frame  = FRAME_W'(r_base + FRAME_W'({r_chk_addr, hit_bit}));
                    n_res_status = STAT_OK;
                    n_chk_vld    = 1'b0;
                    n_state      = FSM_RESP;
                end else if (r_addr < pool_bytes) begin
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_addr[ADDR_W-1:0];
                    n_addr     = PB_W'(r_addr + 1'b1);
                end else if (r_chk_vld) begin
                    n_chk_vld = 1'b0;
                end else begin
                    n_res_frame  = '0;
                    n_res_status = STAT_FULL;
                    n_state      = FSM_RESP;
                end
            end
            FSM_LOCATE: begin
                if (!loc_ok) begin
                    n_res_frame  = r_frame[FRAME_W-1:0];
                    n_res_status = STAT_RANGE;
                    n_state      = FSM_RESP;
                end else begin
                    n_idx   = loc_idx;
                    n_mask  = loc_mask;
                    n_state = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                ram_waddr = r_idx;
                if (r_is_mark) begin
                    if ((ram_rdata & r_mask) == '0) begin
                        n_res_frame  = r_frame[FRAME_W-1:0];
                        n_res_status = STAT_USED;
                        n_state      = FSM_RESP;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~r_mask;
                        n_frame   = OFF_W'(r_frame + 1'b1);
                        n_left    = COUNT_W'(r_left - 1'b1);
                        if (r_left == COUNT_W'(1)) begin
                            n_res_frame  = '0;
                            n_res_status = STAT_OK;
                            n_state      = FSM_RESP;
                        end else begin
                            n_state = FSM_LOCATE;
                        end
                    end
                end else begin
                    if ((ram_rdata & r_mask) != '0) begin
                        n_res_frame  = r_frame[FRAME_W-1:0];
                        n_res_status = STAT_NOT_ALLOC;
                    end else begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata | r_mask;
                        n_res_frame  = '0;
                        n_res_status = STAT_OK;
                    end
                    n_state = FSM_RESP;
                end
            end
            FSM_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_frame  = r_res_frame;
                    n_out_status = r_res_status;
                    n_state      = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_CLEAR;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_addr      <= '0;
            r_sweep     <= '0;
            r_init      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
            r_addr      <= n_addr;
            r_sweep     <= n_sweep;
            r_init      <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_map_bytes <= MAPB_RESET;
            r_reserve   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE:    r_base      <= i_cfg_wdata[FRAME_W-1:0];
                CFG_MAPB:    r_map_bytes <= i_cfg_wdata[MAPB_W-1:0];
                CFG_RESERVE: r_reserve   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame      <= n_frame;
        r_left       <= n_left;
        r_is_mark    <= n_is_mark;
        r_idx        <= n_idx;
        r_mask       <= n_mask;
        r_chk_addr   <= n_chk_addr;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
    end

    assign s_axis_tready = (r_state == FSM_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_status, r_out_frame};

endmodule

### src/bfa_ram.sv
// Generic simple dual-port RAM with registered read.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bfa_checker.sv
// Port-level checks of the bitmap frame allocator, bound to the top level.
module bfa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import bfa_pkg::*;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during the clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    a_full_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[22:20] == STAT_FULL || m_axis_tdata[22:20] == STAT_OK)
        && m_axis_tdata[22:20] == STAT_FULL |-> m_axis_tdata[19:0] == '0)
        else $error("full pool answer carries a frame number");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:20] == STAT_OK || m_axis_tdata[22:20] == STAT_FULL
        || m_axis_tdata[22:20] == STAT_RANGE || m_axis_tdata[22:20] == STAT_USED
        || m_axis_tdata[22:20] == STAT_NOT_ALLOC))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
